/* src/tln_pkg.sv */
// Shared constants, widths and types of the text line normalizer.
`default_nettype none
package tln_pkg;

  // Buffer sizes.
  localparam int MAX_DIGITS    = 8;
  localparam int MAX_SPACE_RUN = 16;

  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
  localparam int DIDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int SCNT_W = $clog2(MAX_SPACE_RUN + 1);
  localparam int SIDX_W = (MAX_SPACE_RUN > 1) ? $clog2(MAX_SPACE_RUN) : 1;

  // Queue between the bracket front end and the back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] UTF_LEAD  = 8'hE2;
  localparam logic [7:0] UTF_MID   = 8'h80;
  localparam logic [7:0] UTF_EN    = 8'h93;
  localparam logic [7:0] UTF_EM    = 8'h94;
  localparam logic [7:0] UTF_LSQ   = 8'h98;
  localparam logic [7:0] UTF_RSQ   = 8'h99;
  localparam logic [7:0] UTF_LDQ   = 8'h9C;
  localparam logic [7:0] UTF_RDQ   = 8'h9D;
  localparam logic [7:0] UTF_ELL   = 8'hA6;
  localparam logic [6:0] CH_DASH   = 7'h2D;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [6:0] CH_APOS   = 7'h27;
  localparam logic [6:0] CH_DOT    = 7'h2E;
  localparam logic [6:0] CH_SPACE  = 7'h20;
  localparam logic [6:0] CH_TAB    = 7'h09;
  localparam logic [6:0] CH_CR     = 7'h0D;

  // One symbol of the stream after bracket removal.
  typedef struct packed {
    logic       eol;
    logic [7:0] chr;
  } sym_t;

  // Write side of the queue.
  typedef struct packed {
    logic valid;
    sym_t sym;
  } qpush_t;

endpackage
`default_nettype wire

/* src/tln_front.sv */
// Front end: accepts input bytes and removes bracketed digit runs.
`default_nettype none
module tln_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,   // [7:0] char_in
  input  wire logic           in_tlast,   // line_end
  input  wire logic           q_full,
  output tln_pkg::qpush_t     q_push
);
  import tln_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_BRK  = 4'b0010,
    F_DIG  = 4'b0100,
    F_TAIL = 4'b1000
  } fstate_t;

  typedef enum logic [2:0] {
    T_CHAR   = 3'b001,
    T_REOPEN = 3'b010,
    T_END    = 3'b100
  } tail_t;

  fstate_t           state_r, state_nxt;
  tail_t             tail_r, tail_nxt;
  logic [7:0]        tail_chr_r, tail_chr_nxt;
  logic              open_r, open_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [DIDX_W-1:0] didx_r, didx_nxt;
  logic [3:0]        dstore_r [MAX_DIGITS];
  logic              dwr;
  logic              accept;
  logic              in_eol;
  logic              in_digit;
  logic              dfull;
  logic              dlast;

  assign in_tready = (state_r == F_IDLE) && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign in_eol    = in_tlast || (in_tdata == CH_NUL);
  assign in_digit  = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign dfull     = (dcnt_r == DCNT_W'(MAX_DIGITS));
  assign dlast     = (DCNT_W'(didx_r) + DCNT_W'(1)) == dcnt_r;

  // Bracket state machine: one queue write per cycle at most.
  always_comb begin
    state_nxt    = state_r;
    tail_nxt     = tail_r;
    tail_chr_nxt = tail_chr_r;
    open_nxt     = open_r;
    dcnt_nxt     = dcnt_r;
    didx_nxt     = didx_r;
    dwr          = 1'b0;
    q_push       = '0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_eol) begin
            if (open_r) begin
              tail_nxt  = T_END;
              state_nxt = F_BRK;
            end else begin
              q_push.valid   = 1'b1;
              q_push.sym.eol = 1'b1;
              q_push.sym.chr = CH_NUL;
            end
          end else if (open_r) begin
            if (in_digit) begin
              if (dfull) begin
                tail_nxt     = T_CHAR;
                tail_chr_nxt = in_tdata;
                state_nxt    = F_BRK;
              end else begin
                dwr      = 1'b1;
                dcnt_nxt = dcnt_r + DCNT_W'(1);
              end
            end else if (in_tdata == CH_RBRACK) begin
              open_nxt = 1'b0;
              dcnt_nxt = '0;
            end else begin
              tail_nxt     = (in_tdata == CH_LBRACK) ? T_REOPEN : T_CHAR;
              tail_chr_nxt = in_tdata;
              state_nxt    = F_BRK;
            end
          end else if (in_tdata == CH_LBRACK) begin
            open_nxt = 1'b1;
            dcnt_nxt = '0;
          end else begin
            q_push.valid   = 1'b1;
            q_push.sym.eol = 1'b0;
            q_push.sym.chr = in_tdata;
          end
        end
      end
      F_BRK: begin
        if (!q_full) begin
          q_push.valid   = 1'b1;
          q_push.sym.chr = CH_LBRACK;
          didx_nxt       = '0;
          state_nxt      = (dcnt_r == '0) ? F_TAIL : F_DIG;
        end
      end
      F_DIG: begin
        if (!q_full) begin
          q_push.valid   = 1'b1;
          q_push.sym.chr = CH_ZERO + {4'h0, dstore_r[didx_r]};
          didx_nxt       = didx_r + DIDX_W'(1);
          if (dlast) begin
            state_nxt = F_TAIL;
          end
        end
      end
      F_TAIL: begin
        unique case (tail_r)
          T_REOPEN: begin
            open_nxt  = 1'b1;
            dcnt_nxt  = '0;
            state_nxt = F_IDLE;
          end
          T_CHAR: begin
            if (!q_full) begin
              q_push.valid   = 1'b1;
              q_push.sym.chr = tail_chr_r;
              open_nxt       = 1'b0;
              dcnt_nxt       = '0;
              state_nxt      = F_IDLE;
            end
          end
          T_END: begin
            if (!q_full) begin
              q_push.valid   = 1'b1;
              q_push.sym.eol = 1'b1;
              q_push.sym.chr = CH_NUL;
              open_nxt       = 1'b0;
              dcnt_nxt       = '0;
              state_nxt      = F_IDLE;
            end
          end
          default: begin
            state_nxt = F_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      tail_r  <= T_CHAR;
      open_r  <= 1'b0;
      dcnt_r  <= '0;
      didx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
      open_r  <= open_nxt;
      dcnt_r  <= dcnt_nxt;
      didx_r  <= didx_nxt;
    end
  end

  // Held byte and digit values.
  always_ff @(posedge clk) begin
    tail_chr_r <= tail_chr_nxt;
    if (dwr) begin
      dstore_r[dcnt_r[DIDX_W-1:0]] <= in_tdata[3:0];
    end
  end

endmodule
`default_nettype wire

/* src/tln_queue.sv */
// Short symbol queue between the front end and the back end.
`default_nettype none
module tln_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tln_pkg::qpush_t q_push,
  output logic                 q_full,
  input  wire logic            q_pop,
  output logic                 q_empty,
  output tln_pkg::sym_t        q_head
);
  import tln_pkg::*;

  sym_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_push.valid && !q_full;
  assign do_pop  = q_pop && !q_empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Symbol storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.sym;
    end
  end

endmodule
`default_nettype wire

/* src/tln_back.sv */
// Back end: UTF-8 punctuation folding, high byte drop and whitespace trimming.
`default_nettype none
module tln_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire tln_pkg::sym_t q_head,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,   // [6:0] char_out, [7] zero fill
  output logic               out_tlast    // line_end_res
);
  import tln_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_TRIM  = 3'b010,
    B_SPACE = 3'b100
  } bstate_t;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEAD = 2'd1;
  localparam logic [1:0] PH_MID  = 2'd2;
  localparam int         SSUM_W  = SCNT_W + 1;

  bstate_t           state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              seen_r, seen_nxt;
  logic [SCNT_W-1:0] scnt_r, scnt_nxt;
  logic [SIDX_W-1:0] shead_r, shead_nxt;
  logic [6:0]        sstore_r [MAX_SPACE_RUN];
  logic [6:0]        cur_r, cur_nxt;
  logic [1:0]        reps_r, reps_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_chr_r, out_chr_nxt;
  logic              out_eol_r, out_eol_nxt;

  logic              out_free;
  logic              swr;
  logic [SIDX_W-1:0] swaddr;
  logic [SSUM_W-1:0] tail_sum;
  logic [SIDX_W-1:0] stail;
  logic [SIDX_W-1:0] shead_inc;
  logic              sfull;
  logic [6:0]        map_chr;
  logic [1:0]        map_reps;
  logic [1:0]        map_phase;
  logic              cur_ws;
  logic              step_done;

  function automatic logic is_ws(input logic [6:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_chr_r};
  assign out_tlast  = out_eol_r;
  assign sfull      = (scnt_r == SCNT_W'(MAX_SPACE_RUN));
  assign cur_ws     = is_ws(cur_r);
  assign shead_inc  = (shead_r == SIDX_W'(MAX_SPACE_RUN - 1)) ? '0 : shead_r + SIDX_W'(1);

  // Write slot of the circular space buffer.
  always_comb begin
    tail_sum = SSUM_W'(shead_r) + SSUM_W'(scnt_r);
    if (tail_sum >= SSUM_W'(MAX_SPACE_RUN)) begin
      tail_sum = tail_sum - SSUM_W'(MAX_SPACE_RUN);
    end
    stail = tail_sum[SIDX_W-1:0];
  end

  // UTF-8 folding of the queue head: gives a char and how many copies.
  always_comb begin
    map_chr   = q_head.chr[6:0];
    map_reps  = 2'd0;
    map_phase = PH_IDLE;
    if ((phase_r == PH_MID) && ((q_head.chr == UTF_EN) || (q_head.chr == UTF_EM))) begin
      map_chr  = CH_DASH;
      map_reps = 2'd1;
    end else if ((phase_r == PH_MID) &&
                 ((q_head.chr == UTF_LDQ) || (q_head.chr == UTF_RDQ))) begin
      map_chr  = CH_DQUOTE;
      map_reps = 2'd1;
    end else if ((phase_r == PH_MID) &&
                 ((q_head.chr == UTF_LSQ) || (q_head.chr == UTF_RSQ))) begin
      map_chr  = CH_APOS;
      map_reps = 2'd1;
    end else if ((phase_r == PH_MID) && (q_head.chr == UTF_ELL)) begin
      map_chr  = CH_DOT;
      map_reps = 2'd3;
    end else if ((phase_r == PH_LEAD) && (q_head.chr == UTF_MID)) begin
      map_phase = PH_MID;
    end else if (q_head.chr == UTF_LEAD) begin
      map_phase = PH_LEAD;
    end else if (!q_head.chr[7]) begin
      map_reps = 2'd1;
    end
  end

  // Back end sequencer.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    seen_nxt      = seen_r;
    scnt_nxt      = scnt_r;
    shead_nxt     = shead_r;
    cur_nxt       = cur_r;
    reps_nxt      = reps_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_chr_nxt   = out_chr_r;
    out_eol_nxt   = out_eol_r;
    q_pop         = 1'b0;
    swr           = 1'b0;
    swaddr        = stail;
    step_done     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_head.eol) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_chr_nxt   = '0;
              out_eol_nxt   = 1'b1;
              phase_nxt     = PH_IDLE;
              seen_nxt      = 1'b0;
              scnt_nxt      = '0;
              shead_nxt     = '0;
              q_pop         = 1'b1;
            end
          end else begin
            q_pop     = 1'b1;
            phase_nxt = map_phase;
            if (map_reps != 2'd0) begin
              cur_nxt   = map_chr;
              reps_nxt  = map_reps;
              state_nxt = B_TRIM;
            end
          end
        end
      end
      B_TRIM: begin
        if (cur_ws) begin
          if (!seen_r) begin
            step_done = 1'b1;
          end else if (!sfull) begin
            swr       = 1'b1;
            scnt_nxt  = scnt_r + SCNT_W'(1);
            step_done = 1'b1;
          end else if (out_free) begin
            // Full buffer: the oldest held byte leaves, the new one takes its slot.
            out_valid_nxt = 1'b1;
            out_chr_nxt   = sstore_r[shead_r];
            out_eol_nxt   = 1'b0;
            swr           = 1'b1;
            swaddr        = shead_r;
            shead_nxt     = shead_inc;
            step_done     = 1'b1;
          end
        end else if (scnt_r != '0) begin
          state_nxt = B_SPACE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_chr_nxt   = cur_r;
          out_eol_nxt   = 1'b0;
          seen_nxt      = 1'b1;
          step_done     = 1'b1;
        end
        if (step_done) begin
          reps_nxt = reps_r - 2'd1;
          if (reps_r == 2'd1) begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_SPACE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_chr_nxt   = sstore_r[shead_r];
          out_eol_nxt   = 1'b0;
          shead_nxt     = shead_inc;
          scnt_nxt      = scnt_r - SCNT_W'(1);
          if (scnt_r == SCNT_W'(1)) begin
            state_nxt = B_TRIM;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      phase_r     <= PH_IDLE;
      seen_r      <= 1'b0;
      scnt_r      <= '0;
      shead_r     <= '0;
      reps_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      seen_r      <= seen_nxt;
      scnt_r      <= scnt_nxt;
      shead_r     <= shead_nxt;
      reps_r      <= reps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers and the space buffer.
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    out_chr_r <= out_chr_nxt;
    out_eol_r <= out_eol_nxt;
    if (swr) begin
      sstore_r[swaddr] <= cur_r;
    end
  end

endmodule
`default_nettype wire

/* src/text_line_normalizer_core.sv */
// Top level of the text line normalizer: front end, queue and back end.
//
// Cleans a text line that streams in one byte per transaction and streams the
// cleaned 7-bit ASCII line out, closed by a marker transaction with tlast set
// and zero data. A byte of zero or in_tlast ends the line. The front end takes
// one byte per cycle while no bracket is being released and the queue is not
// full; releasing a held "[" and its digits as text steps through the bracket,
// digit and tail states, during which in_tready is low. The back end folds
// UTF-8 punctuation in each byte that reaches trimming, then emits or holds
// it, three times for an ellipsis, and flushes held whitespace bytes before
// the next non-whitespace byte. It pops no new byte until the current one is
// done; a 4-entry queue between the two ends absorbs the difference. The output
// stage is a register, and the front end keeps filling the queue while a
// result waits for out_tready.
`default_nettype none
module text_line_normalizer_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] char_in
  input  wire logic       in_tlast,    // line_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [6:0] char_out, [7] zero fill
  output logic            out_tlast    // line_end_res
);
  import tln_pkg::*;

  qpush_t q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  sym_t   q_head;

  // Bracket removal.
  tln_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // Decoupling queue.
  tln_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // UTF-8 folding and trimming.
  tln_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The front end never writes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push.valid && q_full))
    else $error("queue written while full");

  // The line end marker carries no character.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_tvalid && out_tlast |-> out_tdata == 8'h00)
    else $error("line end marker with nonzero data");

  // Results are 7-bit ASCII.
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !out_tdata[7])
    else $error("result byte above 127");

  // The back end never pops an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire
